/* design/assert_macros.svh */
// assertion macros for the smoother core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is asserted
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

/* design/wwts_pkg.sv */
package wwts_pkg;

  localparam int SMP_W = 16;
  localparam int PCT_W = 7;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef logic signed [SMP_W-1:0] smp_t;

  // window control from the sequencer
  typedef struct packed {
    logic sum_start;
    logic push;
  } win_ctrl_t;

endpackage

/* design/wwts_window.sv */
module wwts_window #(
  parameter int DEPTH = 5,
  parameter int CNT_W = 3,
  parameter int SUM_W = 19
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wwts_pkg::win_ctrl_t     ctrl,
  input  wwts_pkg::smp_t          push_data,
  output logic [CNT_W-1:0]        count,
  output logic                    sum_done,
  output logic signed [SUM_W-1:0] sum
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wwts_pkg::smp_t          window_r [DEPTH];
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    busy_r;
  logic                    done_r;
  logic signed [SUM_W-1:0] acc_r;
  logic                    full;
  logic                    last;

  assign full = (count_r == CNT_W'(DEPTH));
  assign last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= !ctrl.sum_start && busy_r && last;
      if (ctrl.sum_start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
      if (ctrl.push && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // one stored sample added per cycle
  always_ff @(posedge clk) begin
    if (ctrl.sum_start) begin
      idx_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + IDX_W'(1);
      acc_r <= acc_r + SUM_W'(window_r[idx_r]);
    end
  end

  // oldest first, drop oldest when full
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (full) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          window_r[i] <= window_r[i+1];
        end
        window_r[DEPTH-1] <= push_data;
      end else begin
        window_r[count_r[IDX_W-1:0]] <= push_data;
      end
    end
  end

  assign count    = count_r;
  assign sum_done = done_r;
  assign sum      = acc_r;

endmodule

/* design/wwts_mul.sv */
module wwts_mul #(
  parameter int DIFF_W = 20,
  parameter int NUM_W  = 28,
  parameter int DEN_W  = 9,
  parameter int CNT_W  = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [DIFF_W-1:0]       diff,
  input  wwts_pkg::smp_t                 sample,
  input  logic [wwts_pkg::PCT_W-1:0]     w,
  input  logic [CNT_W-1:0]               nm1,
  output logic                           done,
  output logic signed [NUM_W-1:0]        num,
  output logic [DEN_W-1:0]               den
);

  localparam int STEP_W = $clog2(wwts_pkg::PCT_W);
  localparam logic signed [NUM_W-1:0] HUNDRED = NUM_W'(wwts_pkg::PCT_FULL);

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_W-1:0]             step_r;
  logic [wwts_pkg::PCT_W-1:0]    w_sh_r;
  logic signed [NUM_W-1:0]       dsh_r;
  logic [DEN_W-1:0]              nsh_r;
  logic signed [NUM_W-1:0]       acc_r;
  logic [DEN_W-1:0]              den_r;
  logic                          last;

  assign last = (step_r == STEP_W'(wwts_pkg::PCT_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift-add over the weight bits: acc = 100*s + diff*w, den = 100 + (n-1)*w
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      w_sh_r <= w;
      dsh_r  <= NUM_W'(diff);
      nsh_r  <= DEN_W'(nm1);
      acc_r  <= NUM_W'(sample) * HUNDRED;
      den_r  <= DEN_W'(wwts_pkg::PCT_FULL);
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      w_sh_r <= w_sh_r >> 1;
      dsh_r  <= dsh_r <<< 1;
      nsh_r  <= nsh_r << 1;
      if (w_sh_r[0]) begin
        acc_r <= acc_r + dsh_r;
        den_r <= den_r + nsh_r;
      end
    end
  end

  assign done = done_r;
  assign num  = acc_r;
  assign den  = den_r;

endmodule

/* design/wwts_div.sv */
module wwts_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output wwts_pkg::smp_t          quot
);

  localparam int QW     = wwts_pkg::SMP_W;
  localparam int STEP_W = $clog2(QW);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic [DEN_W-1:0]  rem_r;
  logic [QW-1:0]     q_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  mag;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic              last;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign last  = (step_r == STEP_W'(QW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per cycle; top bits preload the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      neg_r  <= num[NUM_W-1];
      rem_r  <= DEN_W'(mag >> QW);
      q_r    <= mag[QW-1:0];
      den_r  <= den;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      rem_r  <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      q_r    <= {q_r[QW-2:0], ge};
    end
  end

  // sign restore and clamp to sample range
  always_comb begin
    if (neg_r) begin
      quot = (q_r > QW'(wwts_pkg::SMP_MIN)) ? wwts_pkg::SMP_MIN
                                             : wwts_pkg::smp_t'(QW'(0) - q_r);
    end else begin
      quot = (q_r > QW'(wwts_pkg::SMP_MAX)) ? wwts_pkg::SMP_MAX : wwts_pkg::smp_t'(q_r);
    end
  end

  assign done = done_r;

endmodule

/* design/weighted_window_torque_smoother_core.sv */
// flow: while fewer than two samples are stored, the accepted sample passes through ST_FINISH
//   to the output register; otherwise it goes through the window sum over the stored samples,
//   the 7-step weight multiply and the 16-step restoring divider
// one word in flight: in_stall stays high until the result is moved to the output register
// reset (rst_n low, synchronous): window emptied, smoothing percent 0, no word pending
`include "assert_macros.svh"

module weighted_window_torque_smoother_core #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config
  input  logic                             cfg_wr_en,
  input  logic [wwts_pkg::PCT_W-1:0]       cfg_smoothing_pct,
  // sample in
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wwts_pkg::smp_t                   in_torque_sample,
  // smoothed out
  output logic                             out_valid,
  input  logic                             out_stall,
  output wwts_pkg::smp_t                   out_smoothed_torque
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  // sum of the whole window
  localparam int SUM_W  = wwts_pkg::SMP_W + $clog2(WINDOW_DEPTH);
  // stored sum minus current sample
  localparam int DIFF_W = SUM_W + 1;
  // diff*w + 100*s, w up to 7 bits
  localparam int NUM_W  = DIFF_W + 8;
  // divisor w*(n-1) + 100 never exceeds 100*depth
  localparam int DEN_W  = $clog2(100 * WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t                       state_r;
  logic [wwts_pkg::PCT_W-1:0]   pct_r;
  wwts_pkg::smp_t               sample_r;
  logic [wwts_pkg::PCT_W-1:0]   w_r;
  logic [CNT_W-1:0]             nm1_r;
  wwts_pkg::smp_t               res_r;
  logic                         out_valid_r;
  wwts_pkg::smp_t               out_data_r;

  logic                         accept;
  logic                         few_smp;
  logic [wwts_pkg::PCT_W-1:0]   w_sat;
  wwts_pkg::win_ctrl_t          win_ctrl;
  wwts_pkg::smp_t               push_data;
  logic [CNT_W-1:0]             win_count;
  logic                         sum_done;
  logic signed [SUM_W-1:0]      win_sum;
  logic signed [DIFF_W-1:0]     diff;
  logic                         mul_start;
  logic                         mul_done;
  logic signed [NUM_W-1:0]      num;
  logic [DEN_W-1:0]             den;
  logic                         div_start;
  logic                         div_done;
  wwts_pkg::smp_t               quot;

  // one word in flight; the output register lets the next word in while a result waits
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign few_smp  = (win_count < CNT_W'(2));

  // weights above one hundred saturate
  assign w_sat = (pct_r > wwts_pkg::PCT_FULL) ? wwts_pkg::PCT_FULL : pct_r;

  // with two or more samples stored, the window is summed before the new sample is pushed
  assign win_ctrl.sum_start = accept && !few_smp;
  assign win_ctrl.push      = (accept && few_smp) || ((state_r == ST_SUM) && sum_done);
  assign push_data          = accept ? in_torque_sample : sample_r;

  assign diff      = DIFF_W'(win_sum) - DIFF_W'(sample_r);
  assign mul_start = (state_r == ST_SUM) && sum_done;
  assign div_start = (state_r == ST_MUL) && mul_done;

  wwts_window #(
    .DEPTH (WINDOW_DEPTH),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (win_ctrl),
    .push_data (push_data),
    .count     (win_count),
    .sum_done  (sum_done),
    .sum       (win_sum)
  );

  wwts_mul #(
    .DIFF_W (DIFF_W),
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .CNT_W  (CNT_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .diff   (diff),
    .sample (sample_r),
    .w      (w_r),
    .nm1    (nm1_r),
    .done   (mul_done),
    .num    (num),
    .den    (den)
  );

  wwts_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // smoothing percent register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= '0;
    end else if (cfg_wr_en) begin
      pct_r <= cfg_smoothing_pct;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a word leaving with nothing behind it
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            sample_r <= in_torque_sample;
            w_r      <= w_sat;
            nm1_r    <= win_count - CNT_W'(1);
            if (few_smp) begin
              // raw sample passes through
              res_r   <= in_torque_sample;
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (sum_done) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_r   <= quot;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for the output register to free up
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_smoothed_torque = out_data_r;

  `ASSERT_CLKRST(a_accept_moves_on, clk, rst_n, accept |=> (state_r == ST_SUM || state_r == ST_FINISH), "accepted word did not start work")
  `ASSERT_CLKRST(a_sum_done_in_sum, clk, rst_n, sum_done |-> (state_r == ST_SUM), "window sum finished outside sum phase")
  `ASSERT_CLKRST(a_div_done_in_div, clk, rst_n, div_done |-> (state_r == ST_DIV), "divider finished outside divide phase")
  `ASSERT_CLKRST(a_count_bounded, clk, rst_n, win_count <= CNT_W'(WINDOW_DEPTH), "window count beyond depth")
  `ASSERT_CLK(a_rst_clears_out, clk, !rst_n |=> !out_valid, "reset did not clear pending word")

endmodule
